FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file tmwf_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define TMWF_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
    else $error("%m: assertion failed");

// implication checked in the next cycle
`define TMWF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/tmwf_pkg.sv
// shared constants and types of the trimmed mean window filter
// no dependencies
`timescale 1ns / 1ps

package tmwf_pkg;

  localparam int DATA_W = 32;
  localparam int WINDOW = 5;

  // trim bounds on sorted ranks: keep ranks LO .. HI-1
  localparam int LO_RAW = (WINDOW * 15) / 100;
  localparam int LO     = (LO_RAW < 1) ? 1 : LO_RAW;
  localparam int HI_RAW = (WINDOW * 85) / 100 + 1;
  localparam int HI     = (HI_RAW < WINDOW - 1) ? HI_RAW : WINDOW - 1;
  localparam int CNT    = HI - LO;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);

  // divider retires DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int REM_W     = $clog2(CNT) + 2;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic rank_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rank_last;
    logic div_last;
  } sts_t;

endpackage

FILE: hw/rtl/tmwf_sample_if.sv
// input channel interface carrying one raw sample per request
// depends on tmwf_pkg
`timescale 1ns / 1ps

interface tmwf_sample_if import tmwf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/tmwf_smoothed_if.sv
// result channel interface carrying one smoothed value per request
// depends on tmwf_pkg
`timescale 1ns / 1ps

interface tmwf_smoothed_if import tmwf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t smoothed;

  modport source (output valid, output smoothed, input ready);
  modport sink   (input valid, input smoothed, output ready);
endinterface

FILE: hw/rtl/tmwf_ctrl.sv
// controller state machine of the trimmed mean window filter
// depends on tmwf_pkg; drives tmwf_datapath through cmd_t / sts_t
`timescale 1ns / 1ps

module tmwf_ctrl import tmwf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RANK  = 3'd1;
  localparam logic [2:0] ST_DINIT = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (sts.rank_last) state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        // wait for room in the output register
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/tmwf_datapath.sv
// datapath: window store, rank counter, trimmed accumulator, constant divider
// depends on tmwf_pkg; commanded by tmwf_ctrl
`timescale 1ns / 1ps

module tmwf_datapath import tmwf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  output sts_t    sts,
  input  sample_t in_sample,
  output sample_t out_smoothed
);

  localparam logic [REM_W-1:0]  CNT_R  = REM_W'(CNT);
  localparam logic [RANK_W-1:0] LO_R   = RANK_W'(LO);
  localparam logic [RANK_W-1:0] HI_R   = RANK_W'(HI);
  localparam logic [IDX_W-1:0]  LAST_I = IDX_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_S = STEP_W'(DIV_STEPS - 1);

  sample_t                   store_r [WINDOW];
  logic [IDX_W-1:0]          slot_r, slot_nxt;
  logic [IDX_W-1:0]          idx_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic [DIV_W-1:0]          q_r, q_v;
  logic [REM_W-1:0]          rem_r, rem_v;
  logic [STEP_W-1:0]         step_r;
  logic                      neg_r;
  sample_t                   res_r;
  sample_t                   cur;
  logic [RANK_W-1:0]         rank;
  logic                      in_rng;
  logic [SUM_W-1:0]          mag;

  // slot advances before the write
  assign slot_nxt = (slot_r == LAST_I) ? '0 : slot_r + IDX_W'(1);

  // stable rank of the current entry among the window
  always_comb begin
    cur  = store_r[idx_r];
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((store_r[j] < cur) || ((store_r[j] == cur) && (IDX_W'(j) < idx_r)))
        rank = rank + RANK_W'(1);
    end
  end

  assign in_rng = (rank >= LO_R) && (rank < HI_R);

  assign mag = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);

  // restoring division by the constant count, DIV_BITS bits per cycle
  always_comb begin
    rem_v = rem_r;
    q_v   = q_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_v = {rem_v[REM_W-2:0], q_v[DIV_W-1]};
      q_v   = {q_v[DIV_W-2:0], 1'b0};
      if (rem_v >= CNT_R) begin
        rem_v = rem_v - CNT_R;
        q_v[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) store_r[i] <= '0;
      slot_r <= '0;
    end else if (cmd.load) begin
      store_r[slot_nxt] <= in_sample;
      slot_r            <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      step_r <= '0;
    end else begin
      if (cmd.load) idx_r <= '0;
      else if (cmd.rank_step && (idx_r != LAST_I)) idx_r <= idx_r + IDX_W'(1);
      if (cmd.div_init) step_r <= '0;
      else if (cmd.div_step) step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) acc_r <= '0;
    else if (cmd.rank_step && in_rng) acc_r <= acc_r + SUM_W'(cur);
    if (cmd.div_init) begin
      q_r   <= DIV_W'(mag);
      rem_r <= '0;
      neg_r <= acc_r[SUM_W-1];
    end else if (cmd.div_step) begin
      q_r   <= q_v;
      rem_r <= rem_v;
    end
    if (cmd.out_load) res_r <= neg_r ? -q_r[DATA_W-1:0] : q_r[DATA_W-1:0];
  end

  assign sts.rank_last = (idx_r == LAST_I);
  assign sts.div_last  = (step_r == LAST_S);
  assign out_smoothed  = res_r;

endmodule

FILE: hw/rtl/trimmed_mean_window_filter.sv
// sliding window trimmed mean filter; a new sample is taken only once the
// previous result has passed the one-entry-per-cycle rank scan and the
// 8-bit-per-cycle divider and entered the output register; synchronous
// active-low reset clears the window to zero, the write slot to zero and
// the output register to empty
`timescale 1ns / 1ps

module trimmed_mean_window_filter import tmwf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  tmwf_sample_if.sink     in_if,
  tmwf_smoothed_if.source out_if
);

  // command and status between controller and datapath
  cmd_t    cmd;
  sts_t    sts;
  logic    in_ready;
  logic    out_valid;
  sample_t smoothed;

  // controller: takes a request only when idle, walks the rank scan,
  // the divider and then hands the result to the output register
  tmwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: window registers, rank counter, trimmed sum and divider;
  // the output register lets a new request in while a result still waits
  tmwf_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_if.sample),
    .out_smoothed (smoothed)
  );

  // channel outputs
  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid;
  assign out_if.smoothed = smoothed;

endmodule

FILE: hw/rtl/tmwf_checker.sv
// port-level checker for the trimmed mean window filter, bound to the top
// depends on assert_macros.svh and tmwf_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmwf_checker import tmwf_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_smoothed
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken minus results delivered
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
  end

  `TMWF_ASSERT_ALWAYS(a_pend_cap, clk, rst_n, pend_r != 2'd3)
  `TMWF_ASSERT_ALWAYS(a_no_invent, clk, rst_n, !out_valid || (pend_r != 2'd0))
  `TMWF_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_acc, !in_ready)
  `TMWF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_smoothed))

endmodule

bind trimmed_mean_window_filter tmwf_checker u_tmwf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_smoothed (out_if.smoothed)
);

FILE: tb/tb_trimmed_mean_window_filter.sv
// self-checking testbench for the trimmed mean window filter
// depends on tmwf_pkg, tmwf_sample_if, tmwf_smoothed_if and the filter top level
`timescale 1ns / 1ps

// keeps its own copy of the sample window and queues the expected mean per request
class trim_mean_board;
  localparam int W           = tmwf_pkg::WINDOW;
  localparam int DROP_LO_RAW = (W * 15) / 100;
  localparam int KEEP_LO     = (DROP_LO_RAW < 1) ? 1 : DROP_LO_RAW;
  localparam int KEEP_HI_RAW = (W * 85) / 100 + 1;
  localparam int KEEP_HI     = (KEEP_HI_RAW < W - 1) ? KEEP_HI_RAW : W - 1;

  tmwf_pkg::sample_t history[W];
  int unsigned       slot;
  tmwf_pkg::sample_t expected_means[$];
  int                errors;
  int unsigned       results_seen;

  function new();
    foreach (history[i]) history[i] = '0;
    slot         = 0;
    errors       = 0;
    results_seen = 0;
  endfunction

  function void report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endfunction

  // slot advances first, then the new sample overwrites it
  function void take_sample(tmwf_pkg::sample_t s);
    longint ranked[W];
    longint v;
    longint total;
    int     i;
    int     j;
    slot = (slot + 1 >= W) ? 0 : slot + 1;
    history[slot] = s;
    // insertion sort, zeros from reset take part like any other value
    for (i = 0; i < W; i++) begin
      v = history[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    // full precision sum, division truncates toward zero
    total = 0;
    for (i = KEEP_LO; i < KEEP_HI; i++) total += ranked[i];
    if (KEEP_HI > KEEP_LO)
      expected_means.push_back(tmwf_pkg::sample_t'(total / longint'(KEEP_HI - KEEP_LO)));
    else
      expected_means.push_back('0);
  endfunction

  function void check_smoothed(tmwf_pkg::sample_t got);
    tmwf_pkg::sample_t want;
    if (expected_means.size() == 0) begin
      report($sformatf("result %0d with nothing expected: smoothed %0d",
                       results_seen, got));
    end else begin
      want = expected_means.pop_front();
      if (got !== want)
        report($sformatf("result %0d: smoothed %0d, expected %0d",
                         results_seen, got, want));
    end
    results_seen++;
  endfunction

  function void flag_leftovers();
    while (expected_means.size() != 0)
      report($sformatf("expected smoothed %0d never arrived", expected_means.pop_front()));
  endfunction
endclass

module tb_trimmed_mean_window_filter;
  import tmwf_pkg::*;

  localparam int PHASE_ITEMS  = 475;
  localparam int DRAIN_LIMIT  = 100000;
  localparam int SETTLE_WAIT  = 40;       // wait after the drain for late or extra results

  logic clk;
  logic rst_n;

  tmwf_sample_if   in_if();
  tmwf_smoothed_if out_if();

  trimmed_mean_window_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  trim_mean_board board;

  int      send_idle_pct;
  int      recv_stall_pct;
  sample_t last_sample;

  // directed requests: all-max and all-min windows, sign edges, alternating
  // extremes, bit patterns and ties; the first few also see the reset zeros
  sample_t directed_samples[] = '{
    32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
    32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
    32'sh00000000, -32'sd1, 32'sd1, -32'sd1, 32'sd1,
    32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
    32'sh55555555, 32'shAAAAAAAA,
    32'sd7, 32'sd7, 32'sd7, -32'sd3
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous fixed limit, far past the slowest correct run
  initial begin
    #8000000;
    $display("trimmed_mean_window_filter test failed");
    $finish;
  end

  // receiver: ready changes only at the falling edge
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result check at the rising edge where the request completes
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      board.check_smoothed(out_if.smoothed);
  end

  // mix of full-range, near-zero and near-extreme values, repeats and near-repeats
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 7))
      0, 1, 2: s = $urandom;
      3:       s = $signed($urandom_range(0, 200)) - 100;
      4:       s = 32'sh7FFFFFFF - $urandom_range(0, 3);
      5:       s = 32'sh80000000 + $urandom_range(0, 3);
      6:       s = last_sample;
      default: s = last_sample + $signed($urandom_range(0, 64)) - 32;
    endcase
    return s;
  endfunction

  // called at a falling edge, returns at a falling edge after the request
  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid  = 1'b0;
      in_if.sample = $urandom;   // junk on the bus while idle
      @(negedge clk);
    end
    in_if.valid  = 1'b1;
    in_if.sample = s;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    board.take_sample(s);
    last_sample = s;
    @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < count; k++) send_sample(random_sample());
  endtask

  initial begin
    int guard;
    board          = new();
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    last_sample    = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_samples[i]) send_sample(directed_samples[i]);

    // no idling, idle sender, stalling receiver, then both
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(51, 0, PHASE_ITEMS);
    run_phase(0, 51, PHASE_ITEMS);
    run_phase(30, 30, PHASE_ITEMS);

    in_if.valid    = 1'b0;
    recv_stall_pct = 0;

    guard = 0;
    while (board.expected_means.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    // anything arriving late or extra shows up here
    repeat (SETTLE_WAIT) @(posedge clk);
    board.flag_leftovers();

    if (board.errors == 0)
      $display("trimmed_mean_window_filter test passed");
    else
      $display("trimmed_mean_window_filter test failed");
    $finish;
  end

endmodule
